>>> rtl/core/bpc_pkg.sv
// bpc_pkg: shared types and constants for the button press classifier
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package bpc_pkg;

  // register widths fixed by the register map
  localparam int unsigned DebW = 8;
  localparam int unsigned ThrW = 16;
  localparam int unsigned CfgW = 16;
  localparam int unsigned IdxW = 2;

  localparam logic [DebW-1:0] DebResetVal    = 8'd20;
  localparam logic [ThrW-1:0] NormalResetVal = 16'd1000;
  localparam logic [ThrW-1:0] LongResetVal   = 16'd2000;

  typedef enum logic [IdxW-1:0] {
    CFG_DEBOUNCE = 2'd0,
    CFG_NORMAL   = 2'd1,
    CFG_LONG     = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_SHORT  = 2'd0,
    KIND_NORMAL = 2'd1,
    KIND_LONG   = 2'd2
  } press_kind_e;

  typedef struct packed {
    logic        valid;
    press_kind_e kind;
  } bpc_res_t;

endpackage

`default_nettype wire

>>> rtl/core/bpc_in_if.sv
// bpc_in_if: sample channel, one raw button level per word
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

interface bpc_in_if;
  logic valid;
  logic ready;
  logic raw_level;

  modport source (output valid, output raw_level, input ready);
  modport sink (input valid, input raw_level, output ready);
endinterface

`default_nettype wire

>>> rtl/core/bpc_out_if.sv
// bpc_out_if: event channel, one classified press per word
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

interface bpc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] press_kind;

  modport source (output valid, output press_kind, input ready);
  modport sink (input valid, input press_kind, output ready);
endinterface

`default_nettype wire

>>> rtl/core/bpc_debounce.sv
// bpc_debounce: debounce counter and accepted level
// depends on bpc_pkg
`timescale 1ns / 1ps
`default_nettype none

module bpc_debounce
  import bpc_pkg::*;
#(
  parameter int unsigned BOUNCE_WIDTH = 8
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic            raw_i,
  input  wire logic [DebW-1:0] debounce_ticks_i,
  output logic                 stable_o
);

  localparam int unsigned CmpW = (BOUNCE_WIDTH > DebW) ? BOUNCE_WIDTH : DebW;

  logic                    stable_q, stable_d;
  logic [BOUNCE_WIDTH-1:0] cnt_q, cnt_d, cnt_inc;

  always_comb begin
    stable_d = stable_q;
    cnt_d    = cnt_q;
    cnt_inc  = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;
    if (raw_i == stable_q) begin
      cnt_d = '0;
    end else if (CmpW'(cnt_inc) >= CmpW'(debounce_ticks_i)) begin
      stable_d = raw_i;
      cnt_d    = '0;
    end else begin
      cnt_d = cnt_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q <= 1'b1;
      cnt_q    <= '0;
    end else if (en_i) begin
      stable_q <= stable_d;
      cnt_q    <= cnt_d;
    end
  end

  // level after this sample, seen by the classifier in the same pass
  assign stable_o = stable_d;

endmodule

`default_nettype wire

>>> rtl/core/bpc_hold.sv
// bpc_hold: hold counter and short / normal / long classification
// depends on bpc_pkg
`timescale 1ns / 1ps
`default_nettype none

module bpc_hold
  import bpc_pkg::*;
#(
  parameter int unsigned HOLD_WIDTH = 16
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic            stable_i,
  input  wire logic [ThrW-1:0] normal_ticks_i,
  input  wire logic [ThrW-1:0] long_ticks_i,
  output bpc_res_t             res_o
);

  localparam int unsigned CmpW = (HOLD_WIDTH > ThrW) ? HOLD_WIDTH : ThrW;

  logic                  held_q, held_d;
  logic                  long_sent_q, long_sent_d;
  logic [HOLD_WIDTH-1:0] ticks_q, ticks_d, ticks_inc;

  always_comb begin
    held_d      = held_q;
    long_sent_d = long_sent_q;
    ticks_d     = ticks_q;
    ticks_inc   = (ticks_q == '1) ? ticks_q : ticks_q + 1'b1;
    res_o       = '{valid: 1'b0, kind: KIND_SHORT};
    if (!stable_i && !held_q) begin
      // press accepted: start the count, nothing else this sample
      held_d      = 1'b1;
      ticks_d     = '0;
      long_sent_d = 1'b0;
    end else if (held_q) begin
      ticks_d = ticks_inc;
      if (stable_i) begin
        held_d      = 1'b0;
        res_o.valid = !long_sent_q;
        res_o.kind  = (CmpW'(ticks_inc) >= CmpW'(normal_ticks_i)) ? KIND_NORMAL : KIND_SHORT;
      end else if (!long_sent_q && (CmpW'(ticks_inc) >= CmpW'(long_ticks_i))) begin
        long_sent_d = 1'b1;
        res_o.valid = 1'b1;
        res_o.kind  = KIND_LONG;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= 1'b0;
      long_sent_q <= 1'b0;
      ticks_q     <= '0;
    end else if (en_i) begin
      held_q      <= held_d;
      long_sent_q <= long_sent_d;
      ticks_q     <= ticks_d;
    end
  end

  // only one long event per press
  a_long_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && res_o.valid && res_o.kind == KIND_LONG) |-> (held_q && !long_sent_q))
    else $error("long event with no press or repeated");

  // the count moves by one or sits at saturation while a press goes on
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && held_q) |=>
      (ticks_q == $past(ticks_q) + 1'b1 || ($past(ticks_q) == '1 && ticks_q == '1)))
    else $error("hold count skipped");

endmodule

`default_nettype wire

>>> rtl/core/button_press_classifier_unit.sv
// Button press classifier: debounced short / normal / long press events.
// A sample accepted into the sample register is classified, its event going to
// the event register. Throughput: one sample per cycle (single-pass update)
// unless an event waits untaken; the two registers decouple the two channels.
// Reset: asynchronous, active low; thresholds return to 20 / 1000 / 2000,
// button released, no press in progress.
`timescale 1ns / 1ps
`default_nettype none

module button_press_classifier_unit
  import bpc_pkg::*;
#(
  parameter int unsigned HOLD_WIDTH   = 16,
  parameter int unsigned BOUNCE_WIDTH = 8
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  bpc_in_if.sink               in_if,
  bpc_out_if.source            out_if,
  input  wire logic            cfg_we_i,
  input  wire logic [IdxW-1:0] cfg_idx_i,
  input  wire logic [CfgW-1:0] cfg_data_i
);

  logic [DebW-1:0] deb_q;
  logic [ThrW-1:0] normal_q, long_q;

  logic        in_vld_q, raw_q;
  logic        out_vld_q;
  press_kind_e kind_q;
  logic        advance, stable;
  bpc_res_t    res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_q    <= DebResetVal;
      normal_q <= NormalResetVal;
      long_q   <= LongResetVal;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_DEBOUNCE: deb_q    <= cfg_data_i[DebW-1:0];
        CFG_NORMAL:   normal_q <= cfg_data_i[ThrW-1:0];
        CFG_LONG:     long_q   <= cfg_data_i[ThrW-1:0];
        default: ;
      endcase
    end
  end

  // the sample moves on when the event slot is free or being drained
  assign advance     = in_vld_q && (!out_vld_q || out_if.ready);
  assign in_if.ready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_if.valid && in_if.ready) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      raw_q <= in_if.raw_level;
    end
  end

  bpc_debounce #(
    .BOUNCE_WIDTH(BOUNCE_WIDTH)
  ) u_debounce (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (advance),
    .raw_i           (raw_q),
    .debounce_ticks_i(deb_q),
    .stable_o        (stable)
  );

  bpc_hold #(
    .HOLD_WIDTH(HOLD_WIDTH)
  ) u_hold (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (advance),
    .stable_i      (stable),
    .normal_ticks_i(normal_q),
    .long_ticks_i  (long_q),
    .res_o         (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= res.valid;
    end else if (out_if.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      kind_q <= res.kind;
    end
  end

  assign out_if.valid      = out_vld_q;
  assign out_if.press_kind = kind_q;

  // a stalled sample stays put until the event slot frees
  a_sample_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !advance) |=> (in_vld_q && $stable(raw_q)))
    else $error("pending sample lost");

  // a waiting event is never overwritten by the next sample
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_if.ready) |-> !advance)
    else $error("event overwritten");

  // a waiting event keeps its kind until taken
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_if.ready) |=> (out_vld_q && $stable(kind_q)))
    else $error("waiting event changed");

endmodule

`default_nettype wire
